[hw/rtl/cpid_pkg.sv]
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared constants for the capped cylinder containment and distance unit.
// ----------------------------------------------------------------------------
package cpid_pkg;

    localparam int CPID_COORD_WIDTH = 32;
    localparam int CPID_FRAC_BITS   = 16;

    localparam int CPID_CFG_IDX_W   = 3;

    // configuration register indexes
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_BOTTOM_X = 3'd0;
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_BOTTOM_Y = 3'd1;
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_BOTTOM_Z = 3'd2;
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_TOP_X    = 3'd3;
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_TOP_Y    = 3'd4;
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_TOP_Z    = 3'd5;
    localparam logic [CPID_CFG_IDX_W-1:0] CPID_REG_RADIUS   = 3'd6;

endpackage

[hw/rtl/cpid_delay.sv]
// ----------------------------------------------------------------------------
// cpid_delay
// Fixed-length shift line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module cpid_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_pipe[k] <= '0;
            end
        end else if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

[hw/rtl/cpid_mul_split.sv]
// ----------------------------------------------------------------------------
// cpid_mul_split
// Two-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module cpid_mul_split #(
    parameter int WA = 66,
    parameter int WB = 66
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    output logic [WA+WB-1:0]   o_p
);

    localparam int AL = WA / 2;
    localparam int AH = WA - AL;
    localparam int BL = WB / 2;
    localparam int BH = WB - BL;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [WA+WB-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0]  * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0]  * i_b[WB-1:BL];
            r_hl <= i_a[WA-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[WA-1:AL] * i_b[WB-1:BL];
            r_p  <= (WA+WB)'(r_ll)
                  + ((WA+WB)'(r_lh) << BL)
                  + ((WA+WB)'(r_hl) << AL)
                  + ((WA+WB)'(r_hh) << (AL + BL));
        end
    end

    assign o_p = r_p;

endmodule

[hw/rtl/cpid_div_pipe.sv]
// ----------------------------------------------------------------------------
// cpid_div_pipe
// Restoring divider, one quotient bit per stage. The quotient must fit in
// QW bits (upper half of the numerator below the divisor).
// ----------------------------------------------------------------------------
module cpid_div_pipe #(
    parameter int QW = 66
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*QW-1:0]   i_num,
    input  logic [QW-1:0]     i_den,
    output logic [QW-1:0]     o_quot
);

    localparam int NW = 2 * QW;

    logic [QW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [QW-1:0] w_rem;
        logic [QW-1:0] w_low;
        logic [QW-1:0] w_den;
        logic [QW-1:0] w_q;
        logic [QW:0]   w_trial;
        logic          w_ge;

        if (k == 0) begin : g_head
            assign w_rem = i_num[NW-1:QW];
            assign w_low = i_num[QW-1:0];
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_body
            assign w_rem = r_rem[k-1];
            assign w_low = r_low[k-1];
            assign w_den = r_den[k-1];
            assign w_q   = r_q[k-1];
        end

        assign w_trial = {w_rem, w_low[QW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? QW'(w_trial - {1'b0, w_den}) : w_trial[QW-1:0];
                r_low[k] <= {w_low[QW-2:0], 1'b0};
                r_den[k] <= w_den;
                r_q[k]   <= {w_q[QW-2:0], w_ge};
            end
        end
    end

    assign o_quot = r_q[QW-1];

endmodule

[hw/rtl/cpid_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// cpid_sqrt_pipe
// Integer square root, floor(sqrt(x)), one root bit per stage.
// ----------------------------------------------------------------------------
module cpid_sqrt_pipe #(
    parameter int R = 33
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2*R-1:0]   i_x,
    output logic [R-1:0]     o_root
);

    localparam int N = 2 * R;

    logic [N-1:0] r_x    [R];
    logic [R+1:0] r_rem  [R];
    logic [R-1:0] r_root [R];

    for (genvar k = 0; k < R; k++) begin : g_step
        logic [N-1:0] w_x;
        logic [R+1:0] w_rem;
        logic [R-1:0] w_root;
        logic [R+3:0] w_tt;
        logic [R+3:0] w_trial;
        logic         w_ge;

        if (k == 0) begin : g_head
            assign w_x    = i_x;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_body
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_tt    = {w_rem, w_x[N-1:N-2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = (w_tt >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {w_x[N-3:0], 2'b00};
                r_rem[k]  <= w_ge ? (R+2)'(w_tt - w_trial) : w_tt[R+1:0];
                r_root[k] <= {w_root[R-2:0], w_ge};
            end
        end
    end

    assign o_root = r_root[R-1];

endmodule

[hw/rtl/cylinder_point_inside_and_distance_unit.sv]
// throughput: one point per cycle; the whole pipeline advances unless the result
// register is full and not taken, which holds the input side too
// the depth is set by the two bit-per-stage dividers and the three root extractors
// reset: synchronous active low; clears valid bits and loads the default
// cylinder (axis from origin to z = 1.0, radius 1.0)
// ----------------------------------------------------------------------------
// cylinder_point_inside_and_distance_unit
// Capped cylinder containment test and saturated signed distance, pipelined.
// ----------------------------------------------------------------------------
module cylinder_point_inside_and_distance_unit
    import cpid_pkg::*;
#(
    parameter int COORD_WIDTH = CPID_COORD_WIDTH,
    parameter int FRAC_BITS   = CPID_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [CPID_CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                i_cfg_wdata,
    // points in
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // point_x, point_y, point_z, zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    // results out
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // is_inside, signed_distance, zero fill
    output logic [((COORD_WIDTH+8)/8)*8-1:0]      o_m_tdata
);

    localparam int C     = COORD_WIDTH;
    localparam int DW    = C + 1;
    localparam int PW    = 2 * DW;
    localparam int XW    = 2 * PW;
    localparam int RW    = C - 1;
    localparam int OTW   = ((C + 8) / 8) * 8;
    localparam int T_SQ  = 6 + PW + DW;
    localparam int LAT   = T_SQ + 5 + C;
    localparam logic [C-1:0] LIM = {1'b0, {(C-1){1'b1}}};

    // configuration registers
    logic [C-1:0]  r_bot [3];
    logic [C-1:0]  r_top [3];
    logic [RW-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot[0] <= '0;
            r_bot[1] <= '0;
            r_bot[2] <= '0;
            r_top[0] <= '0;
            r_top[1] <= '0;
            r_top[2] <= C'(1) << FRAC_BITS;
            r_radius <= RW'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CPID_REG_BOTTOM_X: r_bot[0] <= i_cfg_wdata;
                CPID_REG_BOTTOM_Y: r_bot[1] <= i_cfg_wdata;
                CPID_REG_BOTTOM_Z: r_bot[2] <= i_cfg_wdata;
                CPID_REG_TOP_X:    r_top[0] <= i_cfg_wdata;
                CPID_REG_TOP_Y:    r_top[1] <= i_cfg_wdata;
                CPID_REG_TOP_Z:    r_top[2] <= i_cfg_wdata;
                CPID_REG_RADIUS:   r_radius <= i_cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    cpid_delay #(.WIDTH(1), .DEPTH(LAT)) u_valid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(i_s_tvalid), .o_q(o_m_tvalid)
    );

    // stage 1: axis and point offsets from the bottom end
    logic signed [DW-1:0] r1_ax [3];
    logic signed [DW-1:0] r1_tb [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ax[k] <= {r_top[k][C-1], r_top[k]} - {r_bot[k][C-1], r_bot[k]};
                r1_tb[k] <= {i_s_tdata[k*C+C-1], i_s_tdata[k*C +: C]}
                          - {r_bot[k][C-1], r_bot[k]};
            end
        end
    end

    // stage 2: products
    logic signed [PW-1:0] r2_sq [3];
    logic signed [PW-1:0] r2_pd [3];
    logic signed [PW-1:0] r2_x  [6];
    logic [2*RW-1:0]      r2_rr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_sq[k] <= r1_ax[k] * r1_ax[k];
                r2_pd[k] <= r1_ax[k] * r1_tb[k];
            end
            r2_x[0] <= r1_ax[1] * r1_tb[2];
            r2_x[1] <= r1_ax[2] * r1_tb[1];
            r2_x[2] <= r1_ax[2] * r1_tb[0];
            r2_x[3] <= r1_ax[0] * r1_tb[2];
            r2_x[4] <= r1_ax[0] * r1_tb[1];
            r2_x[5] <= r1_ax[1] * r1_tb[0];
            r2_rr   <= r_radius * r_radius;
        end
    end

    // stage 3: squared height, projection, cross product magnitudes
    logic [PW-1:0]      r3_h2;
    logic signed [PW:0] r3_dot;
    logic [PW-1:0]      r3_crm [3];
    logic [2*RW-1:0]    r3_rr;
    logic signed [PW:0] w_cr [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_cr[j] = {r2_x[2*j][PW-1], r2_x[2*j]} - {r2_x[2*j+1][PW-1], r2_x[2*j+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_h2  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_dot <= {r2_pd[0][PW-1], r2_pd[0]} + {r2_pd[1][PW-1], r2_pd[1]}
                    + {r2_pd[2][PW-1], r2_pd[2]};
            for (int j = 0; j < 3; j++) begin
                r3_crm[j] <= w_cr[j][PW] ? PW'(-w_cr[j]) : w_cr[j][PW-1:0];
            end
            r3_rr <= r2_rr;
        end
    end

    // stage 4: distance to the span or to the nearer cap, scaled by height
    logic [PW-1:0]        r4_mag;
    logic                 r4_out;
    logic                 r4_span;
    logic                 r4_h2z;
    logic signed [PW+1:0] w_rest;
    logic                 w_dot_neg;
    logic                 w_rest_neg;

    assign w_rest     = {2'b00, r3_h2} - {r3_dot[PW], r3_dot};
    assign w_dot_neg  = r3_dot[PW];
    assign w_rest_neg = w_rest[PW+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dot_neg) begin
                r4_mag <= PW'(-r3_dot);
            end else if (w_rest_neg) begin
                r4_mag <= PW'(-w_rest);
            end else if (r3_dot[PW-1:0] <= w_rest[PW-1:0]) begin
                r4_mag <= r3_dot[PW-1:0];
            end else begin
                r4_mag <= w_rest[PW-1:0];
            end
            r4_out  <= w_dot_neg || w_rest_neg;
            r4_span <= !w_dot_neg && !w_rest_neg;
            r4_h2z  <= (r3_h2 == '0);
        end
    end

    // stages 4-5: wide squares, split multipliers; the magnitude square starts from the stage 4 register
    logic [XW-1:0]          w_cs [3];
    logic [2*RW+PW-1:0]     w_rrh2;
    logic [XW-1:0]          w_msq;

    for (genvar j = 0; j < 3; j++) begin : g_cross_sq
        cpid_mul_split #(.WA(PW), .WB(PW)) u_mul (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(r3_crm[j]), .i_b(r3_crm[j]), .o_p(w_cs[j])
        );
    end

    cpid_mul_split #(.WA(2*RW), .WB(PW)) u_mul_rrh2 (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(r3_rr), .i_b(r3_h2), .o_p(w_rrh2)
    );

    cpid_mul_split #(.WA(PW), .WB(PW)) u_mul_mag (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(r4_mag), .i_b(r4_mag), .o_p(w_msq)
    );

    // stage 6: area sum; stage 7: containment test
    logic [XW-1:0]       r6_area;
    logic [2*RW+PW-1:0]  r6_rrh2;
    logic                r7_inside;
    logic                w_span6;
    logic [PW-1:0]       w_h2_6;

    cpid_delay #(.WIDTH(1), .DEPTH(2)) u_span_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(r4_span), .o_q(w_span6)
    );

    cpid_delay #(.WIDTH(PW), .DEPTH(3)) u_h2_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(r3_h2), .o_q(w_h2_6)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_area   <= w_cs[0] + w_cs[1] + w_cs[2];
            r6_rrh2   <= w_rrh2;
            r7_inside <= w_span6 && (r6_area <= XW'(r6_rrh2));
        end
    end

    // dividers and roots
    logic [PW-1:0] w_qa;
    logic [PW-1:0] w_qb;
    logic [DW-1:0] w_rho;
    logic [DW-1:0] w_z;

    cpid_div_pipe #(.QW(PW)) u_div_rad (
        .i_clk(i_clk), .i_en(w_en),
        .i_num(r6_area), .i_den(w_h2_6), .o_quot(w_qa)
    );

    cpid_div_pipe #(.QW(PW)) u_div_ax (
        .i_clk(i_clk), .i_en(w_en),
        .i_num(w_msq), .i_den(w_h2_6), .o_quot(w_qb)
    );

    cpid_sqrt_pipe #(.R(DW)) u_sqrt_rad (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_qa), .o_root(w_rho)
    );

    cpid_sqrt_pipe #(.R(DW)) u_sqrt_ax (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_qb), .o_root(w_z)
    );

    logic w_out_t;
    logic w_h2z_e4;
    logic w_in_e4;

    cpid_delay #(.WIDTH(1), .DEPTH(T_SQ - 4)) u_out_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(r4_out), .o_q(w_out_t)
    );

    cpid_delay #(.WIDTH(1), .DEPTH(T_SQ)) u_h2z_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(r4_h2z), .o_q(w_h2z_e4)
    );

    cpid_delay #(.WIDTH(1), .DEPTH(T_SQ - 3)) u_in_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d(r7_inside), .o_q(w_in_e4)
    );

    // e1: radial and axial excess
    logic signed [DW:0] r_e1_dx;
    logic signed [DW:0] r_e1_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_dx <= {1'b0, w_rho} - (DW+1)'(r_radius);
            r_e1_dz <= w_out_t ? {1'b0, w_z} : -{1'b0, w_z};
        end
    end

    // e2: positive parts, overflow check, interior max
    logic               r_e2_pos;
    logic               r_e2_big;
    logic signed [DW:0] r_e2_nmax;
    logic [RW-1:0]      r_e2_px;
    logic [RW-1:0]      r_e2_pz;
    logic               w_xpos;
    logic               w_zpos;
    logic [DW-1:0]      w_px;
    logic [DW-1:0]      w_pz;

    assign w_xpos = !r_e1_dx[DW] && (r_e1_dx != '0);
    assign w_zpos = !r_e1_dz[DW] && (r_e1_dz != '0);
    assign w_px   = w_xpos ? r_e1_dx[DW-1:0] : '0;
    assign w_pz   = w_zpos ? r_e1_dz[DW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_pos  <= w_xpos || w_zpos;
            r_e2_big  <= (w_px > DW'(LIM)) || (w_pz > DW'(LIM));
            r_e2_nmax <= (r_e1_dx < r_e1_dz) ? r_e1_dz : r_e1_dx;
            r_e2_px   <= w_px[RW-1:0];
            r_e2_pz   <= w_pz[RW-1:0];
        end
    end

    // e3: squares; e4: sum
    logic               r_e3_pos;
    logic               r_e3_big;
    logic signed [DW:0] r_e3_nmax;
    logic [2*RW-1:0]    r_e3_sx;
    logic [2*RW-1:0]    r_e3_sz;
    logic               r_e4_pos;
    logic               r_e4_big;
    logic signed [DW:0] r_e4_nmax;
    logic [2*C-1:0]     r_e4_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e3_pos  <= r_e2_pos;
            r_e3_big  <= r_e2_big;
            r_e3_nmax <= r_e2_nmax;
            r_e3_sx   <= r_e2_px * r_e2_px;
            r_e3_sz   <= r_e2_pz * r_e2_pz;
            r_e4_pos  <= r_e3_pos;
            r_e4_big  <= r_e3_big;
            r_e4_nmax <= r_e3_nmax;
            r_e4_sum  <= (2*C)'(r_e3_sx) + (2*C)'(r_e3_sz);
        end
    end

    logic [C-1:0]  w_dist;
    logic          w_h2z_f;
    logic          w_in_f;
    logic          w_pos_f;
    logic          w_big_f;
    logic [DW:0]   w_nmax_f;

    cpid_sqrt_pipe #(.R(C)) u_sqrt_dist (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_e4_sum), .o_root(w_dist)
    );

    cpid_delay #(.WIDTH(DW + 5), .DEPTH(C)) u_flag_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({w_h2z_e4, w_in_e4, r_e4_pos, r_e4_big, r_e4_nmax}),
        .o_q({w_h2z_f, w_in_f, w_pos_f, w_big_f, w_nmax_f})
    );

    // output register
    logic         r_out_inside;
    logic [C-1:0] r_out_dist;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_h2z_f) begin
                r_out_inside <= 1'b0;
                r_out_dist   <= LIM;
            end else begin
                r_out_inside <= w_in_f;
                if (w_pos_f) begin
                    r_out_dist <= (w_big_f || (w_dist > LIM)) ? LIM : w_dist;
                end else begin
                    r_out_dist <= w_nmax_f[C-1:0];
                end
            end
        end
    end

    assign o_m_tdata = OTW'({r_out_dist, r_out_inside});

`ifndef SYNTH
    // an inside point never reports a positive distance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[C] || (o_m_tdata[C:1] == '0)))
        else $error("inside point with positive distance");

    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a degenerate axis always yields the saturated outside result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_h2z_f) |=> (!r_out_inside && (r_out_dist == LIM)))
        else $error("zero-length axis result wrong");
`endif

endmodule

[sim/cylinder_point_inside_and_distance_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cylinder_point_inside_and_distance_unit_tb
// Streams points against a range of cylinders and checks the inside flag and
// the saturated signed distance of every result against an exact predictor.
// ----------------------------------------------------------------------------
module cylinder_point_inside_and_distance_unit_tb;
    import cpid_pkg::*;

    localparam int CW      = CPID_COORD_WIDTH;
    localparam int LATENCY = 4 * CW + 14;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic [CW-1:0] pt [3];
        logic          in_flag;
        logic [CW-1:0] sdist;
    } cyl_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CPID_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0]          i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [95:0]            i_s_tdata = '0;     // point_x, point_y, point_z
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [39:0]            o_m_tdata;          // is_inside, signed_distance, zero fill

    cylinder_point_inside_and_distance_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cylinder mirror: bottom, top, radius
    logic signed [CW-1:0] cyl_bot [3];
    logic signed [CW-1:0] cyl_top [3];
    logic [CW-2:0]        cyl_rad;

    cyl_result_t expected_q [$];
    int  err_cnt = 0;
    int  sent_cnt = 0;
    int  rcvd_cnt = 0;
    int  inside_cnt = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic wide_t isqrt(input logic [255:0] n);
        logic [255:0] res;
        logic [255:0] t;
        res = '0;
        for (int b = 127; b >= 0; b--) begin
            t = res | (256'd1 << b);
            if (t * t <= n) res = t;
        end
        return wide_t'(res);
    endfunction

    function automatic cyl_result_t predict_cylinder(input logic [CW-1:0] p [3]);
        cyl_result_t r;
        wide_t ax [3];
        wide_t tb [3];
        wide_t h2, dot, area, cr, rr, rho, mag, rest, dz, dx, dval, px, pz;
        wide_t lim, nlim, zero;
        bit outside_span;
        lim  = 64'sd2147483647;
        nlim = -64'sd2147483648;
        zero = '0;
        r.pt = p;
        for (int i = 0; i < 3; i++) begin
            ax[i] = wide_t'(cyl_top[i]) - wide_t'(cyl_bot[i]);
            tb[i] = wide_t'(signed'(p[i])) - wide_t'(cyl_bot[i]);
        end
        h2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
        if (h2 == zero) begin
            r.in_flag = 1'b0;
            r.sdist   = lim[CW-1:0];
            return r;
        end
        dot  = ax[0] * tb[0] + ax[1] * tb[1] + ax[2] * tb[2];
        cr   = ax[1] * tb[2] - ax[2] * tb[1];
        area = cr * cr;
        cr   = ax[2] * tb[0] - ax[0] * tb[2];
        area = area + cr * cr;
        cr   = ax[0] * tb[1] - ax[1] * tb[0];
        area = area + cr * cr;
        rr = wide_t'(cyl_rad);
        r.in_flag = (dot >= zero) && (dot <= h2) && (area <= rr * rr * h2);
        rho = isqrt(area / h2);
        if (dot < zero) begin
            mag = -dot;
            outside_span = 1'b1;
        end else begin
            rest = h2 - dot;
            if (rest < zero) begin
                mag = -rest;
                outside_span = 1'b1;
            end else begin
                mag = (dot <= rest) ? dot : rest;
                outside_span = 1'b0;
            end
        end
        dz = isqrt((mag * mag) / h2);
        if (!outside_span) dz = -dz;
        dx = rho - rr;
        if (dx > zero || dz > zero) begin
            px = (dx < zero) ? zero : dx;
            pz = (dz < zero) ? zero : dz;
            if (px > lim || pz > lim) begin
                dval = lim;
            end else begin
                dval = isqrt(px * px + pz * pz);
                if (dval > lim) dval = lim;
            end
        end else begin
            dval = (dx < dz) ? dz : dx;
            if (dval < nlim) dval = nlim;
        end
        r.sdist = dval[CW-1:0];
        return r;
    endfunction

    // result checker and receiver idling
    always @(posedge i_clk) begin
        cyl_result_t e;
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_req = 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rcvd_cnt++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                e = expected_q.pop_front();
                if (e.in_flag) inside_cnt++;
                if (o_m_tdata[0] !== e.in_flag)
                    report($sformatf("is_inside %b exp %b point %h %h %h", o_m_tdata[0],
                        e.in_flag, e.pt[0], e.pt[1], e.pt[2]));
                if (o_m_tdata[CW:1] !== e.sdist)
                    report($sformatf("signed_distance %h exp %h point %h %h %h",
                        o_m_tdata[CW:1], e.sdist, e.pt[0], e.pt[1], e.pt[2]));
                if (o_m_tdata[39:CW+1] !== '0)
                    report($sformatf("fill bits not zero %h", o_m_tdata));
            end
        end
        i_m_tready <= i_rst_n && hold_left <= 1
                      && (no_idle || $urandom_range(99) >= 10);
    end

    task automatic send_point(input logic [CW-1:0] px, py, pz);
        logic [CW-1:0] p [3];
        while (!no_idle && $urandom_range(99) < 10) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        p[0] = px; p[1] = py; p[2] = pz;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pz, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        expected_q.push_back(predict_cylinder(p));
        sent_cnt++;
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_cylinder(input logic [CW-1:0] bx, by, bz, tx, ty, tz,
                                input logic [CW-2:0] rad);
        logic [CW-1:0] v [7];
        v = '{bx, by, bz, tx, ty, tz, {1'b0, rad}};
        drain();
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CPID_CFG_IDX_W'(i);
            i_cfg_wdata <= v[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cyl_bot[0] = bx; cyl_bot[1] = by; cyl_bot[2] = bz;
        cyl_top[0] = tx; cyl_top[1] = ty; cyl_top[2] = tz;
        cyl_rad = rad;
        @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] near(input logic [CW-1:0] c, input int span);
        return c + CW'($urandom_range(2 * span) - span);
    endfunction

    task automatic test_default_cylinder;
        localparam logic [CW-1:0] ONE = 32'h0001_0000;
        localparam logic [CW-1:0] HALF = 32'h0000_8000;
        localparam logic [CW-1:0] MAXV = 32'h7fff_ffff;
        localparam logic [CW-1:0] MINV = 32'h8000_0000;
        send_point(0, 0, HALF);            // on axis, middle
        send_point(0, 0, 0);               // bottom cap center
        send_point(0, 0, ONE);             // top cap center
        send_point(ONE, 0, HALF);          // on side wall
        send_point(0, -ONE, HALF);
        send_point(ONE + 1, 0, HALF);      // just outside radially
        send_point(0, 0, -1);              // just below
        send_point(0, 0, ONE + 1);         // just above
        send_point(2 * ONE, 0, 3 * ONE);   // corner region
        send_point(HALF, HALF, HALF);
        send_point(MAXV, MAXV, MAXV);
        send_point(MINV, MINV, MINV);
        send_point(MAXV, MINV, 0);
        send_point(0, 0, MINV);
        send_point(0, 0, MAXV);
        send_point(ONE, 0, 0);             // bottom rim
    endtask

    task automatic test_zero_length_axis;
        set_cylinder(32'h0003_0000, 32'hfffe_0000, 32'h0001_0000,
                     32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 31'h0001_0000);
        send_point(32'h0003_0000, 32'hfffe_0000, 32'h0001_0000);
        send_point(0, 0, 0);
        send_point($urandom, $urandom, $urandom);
    endtask

    task automatic test_extreme_cylinders;
        set_cylinder(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        send_point(0, 0, 0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        for (int i = 0; i < 20; i++) send_point($urandom, $urandom, $urandom);
        set_cylinder(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 31'd1);
        send_point(0, 0, 0);
        send_point(0, 1, 0);
        send_point(32'h7fff_ffff, 0, 0);
        for (int i = 0; i < 20; i++) send_point($urandom, $urandom, $urandom);
    endtask

    task automatic random_phase(input int n_items, input int span);
        logic [CW-1:0] b [3];
        logic [CW-1:0] t [3];
        logic [CW-1:0] p [3];
        logic [CW-2:0] rad;
        int k;
        for (int i = 0; i < 3; i++) begin
            b[i] = near(0, span);
            t[i] = ($urandom_range(3) == 0) ? b[i] + CW'($urandom_range(1))
                                           : near(b[i], span);
        end
        rad = ($urandom_range(3) == 0) ? (CW-1)'($urandom_range(span, 1))
                                       : (CW-1)'($urandom_range(span / 8 + 1, 1));
        set_cylinder(b[0], b[1], b[2], t[0], t[1], t[2], rad);
        for (int n = 0; n < n_items; n++) begin
            k = $urandom_range(9);
            for (int i = 0; i < 3; i++) begin
                if (k < 2)      p[i] = $urandom;
                else if (k < 4) p[i] = b[i] + (t[i] - b[i]) / 2 + CW'($urandom_range(15)) - 8;
                else            p[i] = near(b[i], span + span / 2);
            end
            send_point(p[0], p[1], p[2]);
        end
    endtask

    task automatic test_random_points;
        no_idle = 1'b0;
        random_phase(250, 1 << 18);
        random_phase(250, 1 << 24);
        no_idle = 1'b1;
        random_phase(200, 1 << 12);
        no_idle = 1'b0;
        random_phase(250, 1 << 29);
    endtask

    task automatic test_backpressure;
        random_phase(20, 1 << 20);
        hold_req = 1'b1;
        random_phase(250, 1 << 20);
        // sender pauses until everything is back, then keeps going
        i_s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge i_clk);
        random_phase(100, 1 << 16);
    endtask

    initial begin
        cyl_bot = '{0, 0, 0};
        cyl_top = '{0, 0, 32'h0001_0000};
        cyl_rad = 31'h0001_0000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_cylinder();
        test_zero_length_axis();
        test_extreme_cylinders();
        test_random_points();
        test_backpressure();
        drain();
        $display("covered %0d points, %0d results back, %0d inside", sent_cnt, rcvd_cnt,
                 inside_cnt);
        $display("cylinders: default, zero-length axis, full-range extremes, random sizes");
        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("** cylinder_point_inside_and_distance_unit: PASSED **");
        end else begin
            $display("** cylinder_point_inside_and_distance_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("timeout after %0d of %0d results", rcvd_cnt, sent_cnt);
        $display("** cylinder_point_inside_and_distance_unit: FAILED **");
        $finish;
    end

endmodule
